### design/csr_sparse_matrix_vector_multiply_macros.svh
// assertion macros for the checker file of the sparse matrix-vector engine
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// clocked assertion, quiet while reset is held
`define CSR_SPMV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also checks through reset
`define CSR_SPMV_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/csr_spmv_pkg.sv
// shared constants and types of the sparse matrix-vector engine
package csr_spmv_pkg;

    localparam int COLUMN_W  = 12;
    localparam int VALUE_W   = 32;
    localparam int SUM_W     = 64;
    localparam int ROW_W     = 20;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 88;
    localparam int M_PAD_W   = M_TDATA_W - SUM_W - ROW_W;

    localparam int VECTOR_DEPTH_DEFAULT = 4096;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic valid;
        logic last;
        logic in_range;
    } stage_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [SUM_W-1:0] row_sum;
    } result_t;

endpackage

### design/csr_spmv_ram.sv
// generic simple dual-port ram with registered read
module csr_spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/csr_spmv_mac.sv
// multiply stage and saturating row accumulator with row counter
module csr_spmv_mac (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  csr_spmv_pkg::stage_t                      s1_ctl,
    input  logic signed [csr_spmv_pkg::VALUE_W-1:0]   s1_value,
    input  logic signed [csr_spmv_pkg::VALUE_W-1:0]   vec_rdata,
    output csr_spmv_pkg::stage_t                      s2_ctl,
    output logic                                      push,
    output csr_spmv_pkg::result_t                     push_data
);

    localparam int SW = csr_spmv_pkg::SUM_W;
    localparam int RW = csr_spmv_pkg::ROW_W;

    csr_spmv_pkg::stage_t   s2_ctl_reg, s2_ctl_next;
    logic signed [SW-1:0]   prod_reg, prod_next;
    logic signed [csr_spmv_pkg::VALUE_W-1:0] vec_x;
    logic signed [SW-1:0]   acc_reg, acc_next;
    logic [RW-1:0]          row_reg, row_next;
    logic signed [SW:0]     wide_sum;
    logic signed [SW-1:0]   sat_sum;

    // columns past the store read as zero
    always_comb begin
        vec_x       = s1_ctl.in_range ? vec_rdata : '0;
        prod_next   = s1_value * vec_x;
        s2_ctl_next = s1_ctl;
    end

    // 65 bit sum, clamp when the two top bits disagree
    always_comb begin
        wide_sum = {acc_reg[SW-1], acc_reg} + {prod_reg[SW-1], prod_reg};
        if (wide_sum[SW] != wide_sum[SW-1]) begin
            sat_sum = wide_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sat_sum = wide_sum[SW-1:0];
        end
    end

    always_comb begin
        acc_next = acc_reg;
        row_next = row_reg;
        if (s2_ctl_reg.valid) begin
            if (s2_ctl_reg.last) begin
                acc_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                acc_next = sat_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_ctl_reg <= '0;
            acc_reg    <= '0;
            row_reg    <= '0;
        end else begin
            s2_ctl_reg <= s2_ctl_next;
            acc_reg    <= acc_next;
            row_reg    <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign s2_ctl              = s2_ctl_reg;
    assign push                = s2_ctl_reg.valid && s2_ctl_reg.last;
    assign push_data.row_sum   = sat_sum;
    assign push_data.row_index = row_reg;

endmodule

### design/csr_spmv_out_fifo.sv
// small result queue between the accumulator and the output channel
module csr_spmv_out_fifo (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   push,
    input  csr_spmv_pkg::result_t                  push_data,
    input  logic                                   pop_ready,
    output logic                                   out_valid,
    output csr_spmv_pkg::result_t                  out_data,
    output logic [csr_spmv_pkg::FIFO_CNT_W-1:0]    count
);

    localparam int PW = csr_spmv_pkg::FIFO_PTR_W;
    localparam int CW = csr_spmv_pkg::FIFO_CNT_W;

    csr_spmv_pkg::result_t mem_reg [csr_spmv_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && pop_ready;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/csr_sparse_matrix_vector_multiply.sv
// top level of the streaming csr sparse matrix-vector engine
//
//  channel | dir | tdata (low bit up)              | tuser | tlast
//  s_      | in  | column[11:0], value[43:12]      | kind  | last_in_row
//  m_      | out | row_sum[63:0], row_index[83:64] | -     | -
//
// one word per cycle on the input side while s_tready is high, loads and nonzeros alike
// a taken nonzero goes through these steps in order on its way to the accumulator:
//   vector ram read, multiply register, accumulate and queue push
// the 4-deep result queue sets the stall point: s_tready drops only when
//   queued plus in-flight row results fill it
// synchronous active-low reset clears control state, the vector ram keeps its contents
module csr_sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = csr_spmv_pkg::VECTOR_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [csr_spmv_pkg::S_TDATA_W-1:0]   s_tdata,   // column, value, zero pad
    input  logic                                 s_tuser,   // kind
    input  logic                                 s_tlast,   // last_in_row
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csr_spmv_pkg::M_TDATA_W-1:0]   m_tdata    // row_sum, row_index, zero pad
);

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int CLW    = csr_spmv_pkg::COLUMN_W;
    localparam int VW     = csr_spmv_pkg::VALUE_W;
    localparam int CNTW   = csr_spmv_pkg::FIFO_CNT_W;

    // input word fields
    logic                 s_fire;
    logic [CLW-1:0]       in_column;
    logic signed [VW-1:0] in_value;
    logic [31:0]          column_ext;
    logic                 in_range;
    logic [ADDR_W-1:0]    vec_addr;

    // stage one: ram read in flight
    csr_spmv_pkg::stage_t s1_ctl_reg, s1_ctl_next;
    logic signed [VW-1:0] s1_value_reg;
    logic signed [VW-1:0] vec_rdata;

    // downstream
    csr_spmv_pkg::stage_t  s2_ctl;
    logic                  push;
    csr_spmv_pkg::result_t push_data;
    csr_spmv_pkg::result_t out_data;
    logic [CNTW-1:0]       fifo_count;
    logic [CNTW-1:0]       pending;

    assign s_fire     = s_tvalid && s_tready;
    assign in_column  = s_tdata[CLW-1:0];
    assign in_value   = s_tdata[CLW+VW-1:CLW];
    assign column_ext = 32'(in_column);
    assign in_range   = (column_ext < 32'(VECTOR_DEPTH));
    assign vec_addr   = column_ext[ADDR_W-1:0];

    // credit check: every row result already queued or still in the pipe holds a slot
    assign pending  = fifo_count + CNTW'(s1_ctl_reg.valid && s1_ctl_reg.last)
                                 + CNTW'(s2_ctl.valid && s2_ctl.last);
    assign s_tready = (pending < CNTW'(csr_spmv_pkg::FIFO_DEPTH));

    // loads write the store at once; a nonzero taken later reads the fresh entry,
    // so load followed by nonzero on the same column needs no bypass
    csr_spmv_ram #(
        .WIDTH (VW),
        .DEPTH (VECTOR_DEPTH)
    ) u_vector_ram (
        .aclk  (aclk),
        .we    (s_fire && !s_tuser && in_range),
        .waddr (vec_addr),
        .wdata (in_value),
        .re    (s_fire && s_tuser),
        .raddr (vec_addr),
        .rdata (vec_rdata)
    );

    // only nonzeros travel on past the ram
    always_comb begin
        s1_ctl_next.valid    = s_fire && s_tuser;
        s1_ctl_next.last     = s_tlast;
        s1_ctl_next.in_range = in_range;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
        end else begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_value_reg <= in_value;
        end
    end

    // multiply, then saturating accumulate and row numbering
    csr_spmv_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s1_ctl    (s1_ctl_reg),
        .s1_value  (s1_value_reg),
        .vec_rdata (vec_rdata),
        .s2_ctl    (s2_ctl),
        .push      (push),
        .push_data (push_data)
    );

    // result queue parts the output handshake from the pipe
    csr_spmv_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_tdata = {{csr_spmv_pkg::M_PAD_W{1'b0}}, out_data.row_index, out_data.row_sum};

endmodule

### design/csr_spmv_checker.sv
// port-level checker for the sparse matrix-vector engine, bound to the top level
`include "csr_sparse_matrix_vector_multiply_macros.svh"

module csr_spmv_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [csr_spmv_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int SW = csr_spmv_pkg::SUM_W;
    localparam int RW = csr_spmv_pkg::ROW_W;

    // row number the next output word must carry
    logic [RW-1:0] exp_row_reg, exp_row_next;

    assign exp_row_next = (m_tvalid && m_tready) ? exp_row_reg + RW'(1) : exp_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_row_reg <= '0;
        end else begin
            exp_row_reg <= exp_row_next;
        end
    end

    `CSR_SPMV_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
    `CSR_SPMV_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result word changed while stalled")
    `CSR_SPMV_ASSERT(a_row_order, m_tvalid |-> m_tdata[SW+RW-1:SW] == exp_row_reg, "row number out of order")
    `CSR_SPMV_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_tvalid, "result word right after reset")
    `CSR_SPMV_ASSERT_RST(a_reset_ready, !aresetn |=> s_tready, "input not ready right after reset")

endmodule

bind csr_sparse_matrix_vector_multiply csr_spmv_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
